>>> hw/rtl/fdrs_pkg.sv
// shared widths, step and micro-op codes, control word types for the deletion-rank select block
package fdrs_pkg;

   // field widths
   localparam int POS_W  = 10;
   localparam int CELL_W = 11;
   localparam int SUM_W  = 15;   // ten cells of eleven bits at most
   localparam int CMP_W  = 17;   // signed room for position minus count

   localparam int TREE_SIZE = 1024;
   localparam logic [POS_W-1:0] LEN_RESET = 10'd1023;

   // sequencer step addresses
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] S_CLR      = 4'd0;
   localparam logic [STEP_W-1:0] S_IDLE     = 4'd1;
   localparam logic [STEP_W-1:0] S_DISP     = 4'd2;
   localparam logic [STEP_W-1:0] S_DEL_INIT = 4'd3;
   localparam logic [STEP_W-1:0] S_DEL_TEST = 4'd4;
   localparam logic [STEP_W-1:0] S_DEL_WR   = 4'd5;
   localparam logic [STEP_W-1:0] S_DEL_FIN  = 4'd6;
   localparam logic [STEP_W-1:0] S_SEL_INIT = 4'd7;
   localparam logic [STEP_W-1:0] S_SEL_TEST = 4'd8;
   localparam logic [STEP_W-1:0] S_Q_TEST   = 4'd9;
   localparam logic [STEP_W-1:0] S_Q_ACC    = 4'd10;
   localparam logic [STEP_W-1:0] S_SEL_CMP  = 4'd11;
   localparam logic [STEP_W-1:0] S_SEL_FIN  = 4'd12;
   localparam logic [STEP_W-1:0] S_OUT      = 4'd13;
   localparam logic [STEP_W-1:0] S_BACK     = 4'd14;

   // datapath micro-ops
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
   localparam logic [OP_W-1:0] OP_CLEAR     = 4'd1;
   localparam logic [OP_W-1:0] OP_LATCH     = 4'd2;
   localparam logic [OP_W-1:0] OP_DEL_INIT  = 4'd3;
   localparam logic [OP_W-1:0] OP_DEL_WRITE = 4'd4;
   localparam logic [OP_W-1:0] OP_SEL_INIT  = 4'd5;
   localparam logic [OP_W-1:0] OP_SEL_MID   = 4'd6;
   localparam logic [OP_W-1:0] OP_Q_ACC     = 4'd7;
   localparam logic [OP_W-1:0] OP_SEL_CMP   = 4'd8;
   localparam logic [OP_W-1:0] OP_FIN_DEL   = 4'd9;
   localparam logic [OP_W-1:0] OP_FIN_SEL   = 4'd10;
   localparam logic [OP_W-1:0] OP_EMIT      = 4'd11;

   // jump conditions
   localparam int COND_W = 4;
   localparam logic [COND_W-1:0] C_NEXT      = 4'd0;
   localparam logic [COND_W-1:0] C_ALWAYS    = 4'd1;
   localparam logic [COND_W-1:0] C_NO_ACCEPT = 4'd2;
   localparam logic [COND_W-1:0] C_CLR_MORE  = 4'd3;
   localparam logic [COND_W-1:0] C_IS_SEL    = 4'd4;
   localparam logic [COND_W-1:0] C_DEL_END   = 4'd5;
   localparam logic [COND_W-1:0] C_LO_GE_HI  = 4'd6;
   localparam logic [COND_W-1:0] C_WALK_ZERO = 4'd7;
   localparam logic [COND_W-1:0] C_RSP_BUSY  = 4'd8;

   // one microcode word
   typedef struct packed {
      logic                take_req;
      logic [OP_W-1:0]     op;
      logic [COND_W-1:0]   cond;
      logic [STEP_W-1:0]   target;
   } ctrl_type;

   // datapath flags seen by the sequencer
   typedef struct packed {
      logic accept;
      logic clr_last;
      logic func_sel;
      logic del_end;
      logic lo_ge_hi;
      logic walk_zero;
      logic rsp_busy;
   } status_type;

endpackage

>>> hw/rtl/fenwick_delete_rank_select.sv
// top level: deleted-position fenwick tree with rank select, microcoded control
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_func, req_position, req_live_rank
//  rsp     | out       | rsp_valid/rsp_stall | rsp_orig_position
//  csr     | in        | csr_valid/csr_ready | csr_list_length
//
// after reset a clearing pass writes zero to every tree cell, with req stalled
// delete: a ram read and a write back for each tree cell updated
// select: per binary search step a prefix walk reads one tree cell per set bit of mid;
//   about log2(list_length) steps, the walk reading cells one at a time over the single ram read port
// a back step follows the result before the next request is taken; a result waits in the rsp
//   register meanwhile, and a stalled rsp holds the sequencer only when a new result is ready
module fenwick_delete_rank_select #(
   parameter int TREE_SIZE = fdrs_pkg::TREE_SIZE
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [fdrs_pkg::POS_W-1:0]   req_position,
   input  logic [fdrs_pkg::POS_W-1:0]   req_live_rank,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [fdrs_pkg::POS_W-1:0]   rsp_orig_position,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [fdrs_pkg::POS_W-1:0]   csr_list_length
);

   fdrs_pkg::ctrl_type           ctrl;
   fdrs_pkg::status_type         status;
   logic [fdrs_pkg::STEP_W-1:0]  step;

   // sequencer
   fdrs_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl),
      .step   (step)
   );

   // datapath and cell store
   fdrs_dp #(
      .TREE_SIZE (TREE_SIZE)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .status            (status),
      .req_valid         (req_valid),
      .req_func          (req_func),
      .req_position      (req_position),
      .req_live_rank     (req_live_rank),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_orig_position (rsp_orig_position),
      .csr_valid         (csr_valid),
      .csr_list_length   (csr_list_length)
   );

   // handshakes
   assign req_stall = !ctrl.take_req;
   assign csr_ready = 1'b1;

   // no request transfer during the clearing pass
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      (step == fdrs_pkg::S_CLR) |-> req_stall)
      else $error("request taken during clearing pass");

   // a request transfer always leads to dispatch
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (step == fdrs_pkg::S_DISP))
      else $error("request transfer did not reach dispatch");

   // a new result only comes from the output step
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(step) == fdrs_pkg::S_OUT))
      else $error("result raised outside output step");

endmodule

>>> hw/rtl/fdrs_ram.sv
// generic simple dual-port ram with registered read
module fdrs_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/fdrs_seq.sv
// microcode sequencer: step counter, control store and conditional jumps
module fdrs_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  fdrs_pkg::status_type          status,
   output fdrs_pkg::ctrl_type            ctrl,
   output logic [fdrs_pkg::STEP_W-1:0]   step
);

   logic [fdrs_pkg::STEP_W-1:0] step_ff;
   logic [fdrs_pkg::STEP_W-1:0] step_in;
   fdrs_pkg::ctrl_type          word;
   logic                        jump;

   // control store
   function automatic fdrs_pkg::ctrl_type rom_word(input logic [fdrs_pkg::STEP_W-1:0] addr);
      fdrs_pkg::ctrl_type w;
      w.take_req = 1'b0;
      w.op       = fdrs_pkg::OP_NONE;
      w.cond     = fdrs_pkg::C_NEXT;
      w.target   = fdrs_pkg::S_IDLE;
      case (addr)
         fdrs_pkg::S_CLR: begin
            w.op = fdrs_pkg::OP_CLEAR; w.cond = fdrs_pkg::C_CLR_MORE;
            w.target = fdrs_pkg::S_CLR;
         end
         fdrs_pkg::S_IDLE: begin
            w.take_req = 1'b1; w.op = fdrs_pkg::OP_LATCH;
            w.cond = fdrs_pkg::C_NO_ACCEPT; w.target = fdrs_pkg::S_IDLE;
         end
         fdrs_pkg::S_DISP: begin
            w.cond = fdrs_pkg::C_IS_SEL; w.target = fdrs_pkg::S_SEL_INIT;
         end
         fdrs_pkg::S_DEL_INIT: begin
            w.op = fdrs_pkg::OP_DEL_INIT;
         end
         fdrs_pkg::S_DEL_TEST: begin
            w.cond = fdrs_pkg::C_DEL_END; w.target = fdrs_pkg::S_DEL_FIN;
         end
         fdrs_pkg::S_DEL_WR: begin
            w.op = fdrs_pkg::OP_DEL_WRITE; w.cond = fdrs_pkg::C_ALWAYS;
            w.target = fdrs_pkg::S_DEL_TEST;
         end
         fdrs_pkg::S_DEL_FIN: begin
            w.op = fdrs_pkg::OP_FIN_DEL; w.cond = fdrs_pkg::C_ALWAYS;
            w.target = fdrs_pkg::S_OUT;
         end
         fdrs_pkg::S_SEL_INIT: begin
            w.op = fdrs_pkg::OP_SEL_INIT;
         end
         fdrs_pkg::S_SEL_TEST: begin
            w.op = fdrs_pkg::OP_SEL_MID; w.cond = fdrs_pkg::C_LO_GE_HI;
            w.target = fdrs_pkg::S_SEL_FIN;
         end
         fdrs_pkg::S_Q_TEST: begin
            w.cond = fdrs_pkg::C_WALK_ZERO; w.target = fdrs_pkg::S_SEL_CMP;
         end
         fdrs_pkg::S_Q_ACC: begin
            w.op = fdrs_pkg::OP_Q_ACC; w.cond = fdrs_pkg::C_ALWAYS;
            w.target = fdrs_pkg::S_Q_TEST;
         end
         fdrs_pkg::S_SEL_CMP: begin
            w.op = fdrs_pkg::OP_SEL_CMP; w.cond = fdrs_pkg::C_ALWAYS;
            w.target = fdrs_pkg::S_SEL_TEST;
         end
         fdrs_pkg::S_SEL_FIN: begin
            w.op = fdrs_pkg::OP_FIN_SEL;
         end
         fdrs_pkg::S_OUT: begin
            w.op = fdrs_pkg::OP_EMIT; w.cond = fdrs_pkg::C_RSP_BUSY;
            w.target = fdrs_pkg::S_OUT;
         end
         fdrs_pkg::S_BACK: begin
            w.cond = fdrs_pkg::C_ALWAYS; w.target = fdrs_pkg::S_IDLE;
         end
         default: begin
            w.cond = fdrs_pkg::C_ALWAYS; w.target = fdrs_pkg::S_IDLE;
         end
      endcase
      return w;
   endfunction

   assign word = rom_word(step_ff);

   // jump condition select
   always_comb begin
      case (word.cond)
         fdrs_pkg::C_NEXT:      jump = 1'b0;
         fdrs_pkg::C_ALWAYS:    jump = 1'b1;
         fdrs_pkg::C_NO_ACCEPT: jump = !status.accept;
         fdrs_pkg::C_CLR_MORE:  jump = !status.clr_last;
         fdrs_pkg::C_IS_SEL:    jump = status.func_sel;
         fdrs_pkg::C_DEL_END:   jump = status.del_end;
         fdrs_pkg::C_LO_GE_HI:  jump = status.lo_ge_hi;
         fdrs_pkg::C_WALK_ZERO: jump = status.walk_zero;
         fdrs_pkg::C_RSP_BUSY:  jump = status.rsp_busy;
         default:               jump = 1'b0;
      endcase
   end

   assign step_in = jump ? word.target : step_ff + fdrs_pkg::STEP_W'(1);

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= fdrs_pkg::S_CLR;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl = word;
   assign step = step_ff;

endmodule

>>> hw/rtl/fdrs_dp.sv
// datapath: tree walk, binary search registers, config and result registers
module fdrs_dp #(
   parameter int TREE_SIZE = fdrs_pkg::TREE_SIZE
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fdrs_pkg::ctrl_type           ctrl,
   output fdrs_pkg::status_type         status,
   input  logic                         req_valid,
   input  logic                         req_func,
   input  logic [fdrs_pkg::POS_W-1:0]   req_position,
   input  logic [fdrs_pkg::POS_W-1:0]   req_live_rank,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [fdrs_pkg::POS_W-1:0]   rsp_orig_position,
   input  logic                         csr_valid,
   input  logic [fdrs_pkg::POS_W-1:0]   csr_list_length
);

   localparam int IDX_W  = $clog2(TREE_SIZE);
   localparam int WALK_W = ((IDX_W > fdrs_pkg::POS_W) ? IDX_W : fdrs_pkg::POS_W) + 1;
   localparam int POS_W  = fdrs_pkg::POS_W;
   localparam int SUM_W  = fdrs_pkg::SUM_W;
   localparam int CMP_W  = fdrs_pkg::CMP_W;
   localparam int CELL_W = fdrs_pkg::CELL_W;

   // control registers
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic [POS_W-1:0]  list_len_ff, list_len_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic              func_ff;
   logic [POS_W-1:0]  pos_ff, rank_ff;
   logic [WALK_W-1:0] walk_ff, walk_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [POS_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [POS_W-1:0]  result_ff, result_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;

   logic              accept;
   logic              rsp_busy;
   logic [WALK_W-1:0] low_bit;
   logic              walk_in_tree;
   logic [POS_W:0]    lo_hi_sum;
   logic [CMP_W-1:0]  live;
   logic              live_short;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [CELL_W-1:0] ram_wdata;
   logic [CELL_W-1:0] ram_rdata;

   assign accept   = req_valid && ctrl.take_req;
   assign rsp_busy = rsp_valid_ff && rsp_stall;

   // tree walk helpers
   assign low_bit      = walk_ff & (~walk_ff + WALK_W'(1));
   assign walk_in_tree = walk_ff < WALK_W'(TREE_SIZE);
   assign lo_hi_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign live         = CMP_W'(mid_ff) - CMP_W'(sum_ff);
   assign live_short   = $signed(live) < $signed(CMP_W'(rank_ff));

   // cell store
   assign ram_we    = (ctrl.op == fdrs_pkg::OP_CLEAR) || (ctrl.op == fdrs_pkg::OP_DEL_WRITE);
   assign ram_waddr = (ctrl.op == fdrs_pkg::OP_CLEAR) ? clr_ff : walk_ff[IDX_W-1:0];
   assign ram_wdata = (ctrl.op == fdrs_pkg::OP_CLEAR) ? '0 : ram_rdata + CELL_W'(1);

   fdrs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (TREE_SIZE)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (walk_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   // micro-op decode
   always_comb begin
      clr_in       = clr_ff;
      list_len_in  = csr_valid ? csr_list_length : list_len_ff;
      walk_in      = walk_ff;
      sum_in       = sum_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      result_in    = result_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (ctrl.op)
         fdrs_pkg::OP_CLEAR: begin
            clr_in = clr_ff + IDX_W'(1);
         end
         fdrs_pkg::OP_DEL_INIT: begin
            walk_in = WALK_W'(pos_ff);
         end
         fdrs_pkg::OP_DEL_WRITE: begin
            walk_in = walk_ff + low_bit;
         end
         fdrs_pkg::OP_SEL_INIT: begin
            lo_in = POS_W'(1);
            hi_in = list_len_ff;
         end
         fdrs_pkg::OP_SEL_MID: begin
            mid_in  = lo_hi_sum[POS_W:1];
            walk_in = WALK_W'(lo_hi_sum[POS_W:1]);
            sum_in  = '0;
         end
         fdrs_pkg::OP_Q_ACC: begin
            if (walk_in_tree) begin
               sum_in = sum_ff + SUM_W'(ram_rdata);
            end
            walk_in = walk_ff - low_bit;
         end
         fdrs_pkg::OP_SEL_CMP: begin
            if (live_short) begin
               lo_in = mid_ff + POS_W'(1);
            end else begin
               hi_in = mid_ff;
            end
         end
         fdrs_pkg::OP_FIN_DEL: begin
            result_in = '0;
         end
         fdrs_pkg::OP_FIN_SEL: begin
            result_in = hi_ff;
         end
         fdrs_pkg::OP_EMIT: begin
            if (!rsp_busy) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = result_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         list_len_ff  <= fdrs_pkg::LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         list_len_ff  <= list_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload state, request fields captured on transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         pos_ff  <= req_position;
         rank_ff <= req_live_rank;
      end
      walk_ff    <= walk_in;
      sum_ff     <= sum_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      result_ff  <= result_in;
      rsp_pos_ff <= rsp_pos_in;
   end

   // flags for the sequencer
   assign status.accept    = accept;
   assign status.clr_last  = clr_ff == IDX_W'(TREE_SIZE - 1);
   assign status.func_sel  = func_ff;
   assign status.del_end   = (walk_ff == '0) || !walk_in_tree;
   assign status.lo_ge_hi  = lo_ff >= hi_ff;
   assign status.walk_zero = walk_ff == '0;
   assign status.rsp_busy  = rsp_busy;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_orig_position = rsp_pos_ff;

endmodule
